>>> rtl/pmad_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pmad_pkg
// Shared types and constants of the peak meter.
// ----------------------------------------------------------------------------
package pmad_pkg;

   localparam int signed HOLD_FLOOR = -40960;
   localparam int signed DB_FLOOR   = -25600;
   localparam logic [18:0] LOG_SCALE = 19'd394566;
   localparam logic [23:0] ACC_MAX  = 24'hFFFFFF;
   localparam logic [15:0] CNT_MAX  = 16'hFFFF;

   localparam logic CSR_ENABLE = 1'b0;
   localparam logic CSR_DECAY  = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_LOG,
      ST_MUL,
      ST_WRITE,
      ST_OUT,
      ST_CLEAR
   } state_type;

   typedef struct packed {
      logic [23:0]        peak_mag;
      logic [15:0]        count;
      logic signed [16:0] held;
      logic signed [16:0] max_hold;
      logic [23:0]        decay_acc;
   } entry_type;

   typedef struct packed {
      logic        start;
      logic [23:0] mag;
   } log_req_type;

   typedef struct packed {
      logic               done;
      logic signed [15:0] db;
   } log_rsp_type;

endpackage
`default_nettype wire

>>> rtl/peak_meter_accel_decay.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// peak_meter_accel_decay
// Per-channel peak meter with accelerating decay and max hold.
// ----------------------------------------------------------------------------
// Channel state lives in one synchronous memory (one entry per channel).
// A sample that does not end a block is accepted, read, updated and written
// back before the next beat is taken. A block-end sample also runs the dB
// conversion (mantissa squarings, then multiply, round and hand-off) and the
// decay multiply; its result is loaded into the result register, and the
// next beat is taken after that load. If the result register still holds an
// unaccepted result, the input stalls until it drains. A clear beat sweeps
// the memory before the next beat is taken. After reset the input stalls
// while a clearing pass initializes the memory.
module peak_meter_accel_decay #(
   parameter int CHANNELS    = 2,
   parameter int SAMPLE_BITS = 24
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   output logic              req_stall,
   input  wire               req_type,
   input  wire  [3:0]        req_channel,
   input  wire  signed [23:0] req_sample,
   input  wire               req_block_end,
   output logic              rsp_valid,
   input  wire               rsp_stall,
   output logic [3:0]        rsp_out_channel,
   output logic signed [15:0] rsp_block_peak_db,
   output logic signed [16:0] rsp_held_peak_db,
   output logic signed [16:0] rsp_max_peak_db,
   input  wire               csr_valid,
   output logic              csr_ready,
   input  wire               csr_index,
   input  wire  [23:0]       csr_data
);
   import pmad_pkg::*;

   localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   entry_type mem [CHANNELS];
   entry_type rd_ff;

   state_type st_ff, st_in;
   logic              en_ff;
   logic [23:0]       decay_ff;
   logic [AW:0]       sweep_ff, sweep_in;
   logic              init_ff, init_in;
   logic [AW-1:0]     ch_ff, ch_in;
   logic [23:0]       mag_ff, mag_in;
   logic              be_ff, be_in;
   entry_type         e_ff, e_in;
   logic [39:0]       blk_ff, blk_in;
   logic              we;
   logic [AW-1:0]     waddr, raddr;
   entry_type         wdata;
   logic              rsp_valid_ff, rsp_load;
   logic [3:0]        och_ff;
   logic signed [15:0] bdb_ff, bdbr_ff;
   logic signed [16:0] held_ff, max_ff;
   log_req_type       lstart;
   log_rsp_type       lrsp;
   entry_type         upd;

   logic [SAMPLE_BITS-1:0] raw;
   logic [SAMPLE_BITS-1:0] negraw;
   logic [23:0]       mag_new;
   logic              take;
   logic signed [17:0] cur;
   logic [40:0]       acc;
   entry_type         clr;

   assign raw    = SAMPLE_BITS'($unsigned(req_sample));
   assign negraw = ~raw + 1'b1;
   assign mag_new = raw[SAMPLE_BITS-1] ? 24'(negraw == '0 ? {1'b1, {(SAMPLE_BITS-1){1'b0}}}
                                                        : negraw)
                                       : 24'(raw);

   assign req_stall = (st_ff != ST_IDLE) || init_ff;
   assign take      = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   pmad_log #(.SAMPLE_BITS(SAMPLE_BITS)) u_log (
      .clock(clock), .reset(reset), .req(lstart), .rsp(lrsp)
   );

   assign cur = 18'($signed(e_ff.held)) - $signed({2'b00, e_ff.decay_acc[23:8]});
   assign acc = 41'(e_ff.decay_acc) + 41'(blk_ff);

   always_comb begin
      clr          = '0;
      clr.held     = 17'(HOLD_FLOOR);
      clr.max_hold = 17'(HOLD_FLOOR);
   end

   always_comb begin
      st_in    = st_ff;
      sweep_in = sweep_ff;
      init_in  = init_ff;
      ch_in    = ch_ff;
      mag_in   = mag_ff;
      be_in    = be_ff;
      case (st_ff)
         ST_IDLE: begin
            if (init_ff) begin
               sweep_in = sweep_ff + 1'b1;
               if (sweep_ff == (AW+1)'(CHANNELS - 1)) init_in = 1'b0;
            end else if (take) begin
               if (req_type) begin
                  sweep_in = '0;
                  st_in    = ST_CLEAR;
               end else if (en_ff && 32'(req_channel) < CHANNELS) begin
                  ch_in  = AW'(req_channel);
                  mag_in = mag_new;
                  be_in  = req_block_end;
                  st_in  = ST_READ;
               end
            end
         end
         ST_READ:  st_in = ST_LOG;
         ST_LOG: begin
            if (!be_ff) st_in = ST_WRITE;
            else if (lrsp.done) st_in = ST_MUL;
         end
         ST_MUL:   st_in = ST_WRITE;
         ST_WRITE: st_in = be_ff ? ST_OUT : ST_IDLE;
         ST_OUT:   if (!rsp_valid_ff || !rsp_stall) st_in = ST_IDLE;
         ST_CLEAR: begin
            sweep_in = sweep_ff + 1'b1;
            if (sweep_ff == (AW+1)'(CHANNELS)) st_in = ST_IDLE;
         end
         default:  st_in = ST_IDLE;
      endcase
   end

   always_comb begin
      e_in       = e_ff;
      blk_in     = blk_ff;
      we         = 1'b0;
      waddr      = ch_ff;
      wdata      = e_ff;
      raddr      = ch_ff;
      rsp_load   = 1'b0;
      case (st_ff)
         ST_IDLE: begin
            we    = init_ff;
            waddr = AW'(sweep_ff);
            wdata = clr;
            raddr = AW'(req_channel);
         end
         ST_READ: e_in = upd;
         ST_MUL: begin
            blk_in = 40'(decay_ff) * 40'(e_ff.count);
         end
         ST_WRITE: begin
            we    = 1'b1;
            wdata = e_ff;
            if (be_ff) begin
               if (cur <= 18'(bdb_ff)) begin
                  wdata.held      = 17'(bdb_ff);
                  wdata.decay_acc = '0;
               end else begin
                  wdata.held = (cur < 18'(HOLD_FLOOR)) ? 17'(HOLD_FLOOR) : cur[16:0];
                  wdata.decay_acc = (acc > 41'(ACC_MAX)) ? ACC_MAX : acc[23:0];
               end
               if (17'(bdb_ff) > e_ff.max_hold) wdata.max_hold = 17'(bdb_ff);
               wdata.peak_mag = '0;
               wdata.count    = '0;
            end
            e_in = wdata;
         end
         ST_OUT:   rsp_load = !rsp_valid_ff || !rsp_stall;
         ST_CLEAR: begin
            raddr = AW'(sweep_ff);
            if (sweep_ff != '0) begin
               we             = 1'b1;
               waddr          = AW'(sweep_ff - 1'b1);
               wdata          = rd_ff;
               wdata.held     = 17'(HOLD_FLOOR);
               wdata.max_hold = 17'(HOLD_FLOOR);
            end
         end
         default: ;
      endcase
   end

   // modified entry after read
   always_comb begin
      upd = rd_ff;
      if (mag_ff > rd_ff.peak_mag) upd.peak_mag = mag_ff;
      if (rd_ff.count != CNT_MAX) upd.count = rd_ff.count + 16'd1;
   end

   // start the converter on the updated block peak
   assign lstart.start = (st_ff == ST_READ) && be_ff;
   assign lstart.mag   = upd.peak_mag;

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rd_ff <= mem[raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= ST_IDLE;
         en_ff        <= 1'b1;
         decay_ff     <= 24'd16;
         sweep_ff     <= '0;
         init_ff      <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff    <= st_in;
         sweep_ff <= sweep_in;
         init_ff  <= init_in;
         if (csr_valid) begin
            case (csr_index)
               CSR_ENABLE: en_ff    <= csr_data[0];
               CSR_DECAY:  decay_ff <= csr_data;
               default: ;
            endcase
         end
         if (rsp_load) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
      end
      ch_ff  <= ch_in;
      mag_ff <= mag_in;
      be_ff  <= be_in;
      blk_ff <= blk_in;
      e_ff   <= e_in;
      if (lrsp.done) bdb_ff <= lrsp.db;
      if (rsp_load) begin
         och_ff  <= 4'(ch_ff);
         bdbr_ff <= bdb_ff;
         held_ff <= e_ff.held;
         max_ff  <= e_ff.max_hold;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_channel   = och_ff;
   assign rsp_block_peak_db = bdbr_ff;
   assign rsp_held_peak_db  = held_ff;
   assign rsp_max_peak_db   = max_ff;

   assert property (@(posedge clock) disable iff (reset)
      (take && st_in != ST_IDLE) |=> req_stall)
      else $error("beat taken while busy");
   assert property (@(posedge clock) disable iff (reset)
      (st_ff == ST_OUT && st_in == ST_IDLE) |=> rsp_valid)
      else $error("result lost");
   assert property (@(posedge clock) disable iff (reset) init_ff |-> req_stall)
      else $error("beat taken during init");
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_out_channel) &&
      $stable(rsp_block_peak_db) && $stable(rsp_held_peak_db) && $stable(rsp_max_peak_db)))
      else $error("stalled result changed");

endmodule
`default_nettype wire

>>> rtl/pmad_log.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pmad_log
// Iterative log2 to dB converter: one mantissa squaring per cycle.
// ----------------------------------------------------------------------------
module pmad_log #(
   parameter int SAMPLE_BITS = 24
) (
   input  wire                   clock,
   input  wire                   reset,
   input  pmad_pkg::log_req_type req,
   output pmad_pkg::log_rsp_type rsp
);
   import pmad_pkg::*;

   localparam int PW = $clog2(SAMPLE_BITS);

   typedef enum logic [1:0] {L_IDLE, L_SQR, L_MUL, L_RND} lstate_type;

   lstate_type         st_ff, st_in;
   logic [31:0]        m_ff, m_in;
   logic [15:0]        frac_ff, frac_in;
   logic [4:0]         it_ff, it_in;
   logic [PW-1:0]      p_ff, p_in;
   logic               zero_ff, zero_in;
   logic [40:0]        prod_ff, prod_in;
   logic signed [15:0] db_ff, db_in;
   logic               done_ff, done_in;

   logic [63:0]        sq;
   logic [32:0]        sqs;
   logic [PW-1:0]      msb;
   logic [21:0]        neg;
   logic [17:0]        q;

   always_comb begin
      msb = '0;
      for (int i = 0; i < 24; i++) begin
         if (req.mag[i]) msb = PW'(i);
      end
   end

   assign sq  = m_ff * m_ff;
   assign sqs = sq[63:31];
   assign neg = {(PW'(SAMPLE_BITS - 1) - p_ff), 16'd0} - {6'd0, frac_ff};
   assign q   = 18'((prod_ff + 41'd8388608) >> 24);

   always_comb begin
      st_in   = st_ff;
      m_in    = m_ff;
      frac_in = frac_ff;
      it_in   = it_ff;
      p_in    = p_ff;
      zero_in = zero_ff;
      prod_in = prod_ff;
      db_in   = db_ff;
      done_in = 1'b0;
      case (st_ff)
         L_IDLE: begin
            if (req.start) begin
               p_in    = msb;
               zero_in = (req.mag == '0);
               m_in    = 32'({8'd0, req.mag} << (5'd31 - 5'(msb)));
               frac_in = '0;
               it_in   = '0;
               st_in   = L_SQR;
            end
         end
         L_SQR: begin
            if (sqs[32]) begin
               frac_in = {frac_ff[14:0], 1'b1};
               m_in    = sqs[32:1];
            end else begin
               frac_in = {frac_ff[14:0], 1'b0};
               m_in    = sqs[31:0];
            end
            it_in = it_ff + 5'd1;
            if (it_ff == 5'd15) st_in = L_MUL;
         end
         L_MUL: begin
            prod_in = 41'(neg) * 41'(LOG_SCALE);
            st_in   = L_RND;
         end
         L_RND: begin
            if (zero_ff || q >= 18'd25600) db_in = 16'(DB_FLOOR);
            else db_in = -$signed({1'b0, q[14:0]});
            done_in = 1'b1;
            st_in   = L_IDLE;
         end
         default: st_in = L_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= L_IDLE;
         done_ff <= 1'b0;
      end else begin
         st_ff   <= st_in;
         done_ff <= done_in;
      end
      m_ff    <= m_in;
      frac_ff <= frac_in;
      it_ff   <= it_in;
      p_ff    <= p_in;
      zero_ff <= zero_in;
      prod_ff <= prod_in;
      db_ff   <= db_in;
   end

   assign rsp.done = done_ff;
   assign rsp.db   = db_ff;

endmodule
`default_nettype wire

>>> test/peak_meter_accel_decay_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// peak_meter_accel_decay_tb
// Self-checking bench for the peak meter: a directed table followed by
// random interleaved traffic under several idle and stall mixes. A local
// model tracks per-channel peaks, decay and max hold and predicts each beat.
// ----------------------------------------------------------------------------
module peak_meter_accel_decay_tb;
   import pmad_pkg::*;

   localparam int NCH       = 2;
   localparam int DOG_LIMIT = 5000;

   typedef struct {
      logic [3:0]         ch;
      logic signed [15:0] bdb;
      logic signed [16:0] held;
      logic signed [16:0] mx;
   } meter_beat_type;

   typedef struct {
      logic           typ;
      logic [3:0]     ch;
      logic [23:0]    smp;
      logic           be;
      bit             typed;
      meter_beat_type want;
   } dir_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0, req_type = 1'b0, req_block_end = 1'b0;
   logic [3:0] req_channel = '0;
   logic signed [23:0] req_sample = '0;
   logic req_stall;
   logic rsp_valid, rsp_stall = 1'b0;
   logic [3:0] rsp_out_channel;
   logic signed [15:0] rsp_block_peak_db;
   logic signed [16:0] rsp_held_peak_db, rsp_max_peak_db;
   logic csr_valid = 1'b0, csr_index = 1'b0;
   logic [23:0] csr_data = '0;
   logic csr_ready;

   peak_meter_accel_decay uut (.*);

   initial begin
      forever #1 clock = ~clock;
   end

   // meter model state
   bit          m_en;
   logic [23:0] m_decay;
   logic [23:0] m_pk[NCH];
   logic [15:0] m_cnt[NCH];
   int          m_held[NCH], m_max[NCH];
   logic [23:0] m_acc[NCH];

   meter_beat_type pending_beats[$];
   int errors = 0;
   int send_idle = 0, stall_pct = 0;
   bit hold_req = 0;
   int dog = 0;

   task automatic report(input string what, input int got, input int want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      errors++;
   endtask

   function automatic int level_db(input logic [23:0] mag);
      int p;
      logic [63:0] m, neg, q;
      logic [15:0] frac;
      p = 0;
      frac = '0;
      if (mag == 0) return DB_FLOOR;
      for (int i = 23; i >= 0; i--) if (mag[i]) begin
         p = i;
         break;
      end
      m = 64'(mag) << (31 - p);
      for (int i = 0; i < 16; i++) begin
         m = (m * m) >> 31;
         frac = frac << 1;
         if (m >= 64'h1_0000_0000) begin
            frac[0] = 1'b1;
            m = m >> 1;
         end
      end
      neg = (64'(23 - p) << 16) - 64'(frac);
      q = (neg * 64'(LOG_SCALE) + 64'h80_0000) >> 24;
      if (q >= 64'(-DB_FLOOR)) return DB_FLOOR;
      return -int'(q);
   endfunction

   function automatic void meter_reset();
      m_en = 1;
      m_decay = 24'd16;
      for (int c = 0; c < NCH; c++) begin
         m_pk[c] = '0;
         m_cnt[c] = '0;
         m_held[c] = HOLD_FLOOR;
         m_max[c] = HOLD_FLOOR;
         m_acc[c] = '0;
      end
   endfunction

   // returns 1 when the item finishes a block
   function automatic bit meter_step(input logic typ, input logic [3:0] ch,
                                     input logic [23:0] smp, input logic be,
                                     output meter_beat_type b);
      logic [23:0] mag;
      int bdb, cur;
      logic [63:0] acc;
      b = '{default: '0};
      if (typ) begin
         for (int c = 0; c < NCH; c++) begin
            m_held[c] = HOLD_FLOOR;
            m_max[c] = HOLD_FLOOR;
         end
         return 0;
      end
      if (!m_en || ch >= NCH) return 0;
      mag = smp[23] ? -smp : smp;
      if (mag > m_pk[ch]) m_pk[ch] = mag;
      if (m_cnt[ch] != CNT_MAX) m_cnt[ch]++;
      if (!be) return 0;
      bdb = level_db(m_pk[ch]);
      cur = m_held[ch] - int'(m_acc[ch] >> 8);
      if (cur <= bdb) begin
         m_held[ch] = bdb;
         m_acc[ch] = '0;
      end else begin
         m_held[ch] = (cur < HOLD_FLOOR) ? HOLD_FLOOR : cur;
         acc = 64'(m_acc[ch]) + 64'(m_decay) * 64'(m_cnt[ch]);
         m_acc[ch] = (acc > 64'(ACC_MAX)) ? ACC_MAX : acc[23:0];
      end
      if (bdb > m_max[ch]) m_max[ch] = bdb;
      m_pk[ch] = '0;
      m_cnt[ch] = '0;
      b.ch = ch;
      b.bdb = 16'(bdb);
      b.held = 17'(m_held[ch]);
      b.mx = 17'(m_max[ch]);
      return 1;
   endfunction

   task automatic send_item(input logic typ, input logic [3:0] ch, input logic [23:0] smp,
                            input logic be, input bit typed, input meter_beat_type want);
      meter_beat_type b;
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_type <= typ;
      req_channel <= ch;
      req_sample <= smp;
      req_block_end <= be;
      do @(posedge clock); while (req_stall);
      if (meter_step(typ, ch, smp, be, b)) begin
         if (typed) pending_beats.push_back(want);
         else pending_beats.push_back(b);
      end
   endtask

   task automatic send_random();
      logic typ, be;
      logic [3:0] ch;
      logic [23:0] smp;
      typ = ($urandom_range(39) == 0);
      ch = ($urandom_range(19) == 0) ? 4'($urandom) : 4'($urandom_range(NCH - 1));
      case ($urandom_range(5))
         0: smp = 24'($urandom_range(255));
         1: smp = -24'($urandom_range(255));
         2: smp = 24'($urandom) >> $urandom_range(23);
         default: smp = 24'($urandom);
      endcase
      be = ($urandom_range(4) == 0);
      send_item(typ, ch, smp, be, 0, '{default: '0});
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_beats.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic csr_write(input logic idx, input logic [23:0] val);
      drain();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_ENABLE) m_en = val[0];
      else m_decay = val;
   endtask

   // result side: random stall, long hold-off on request, compare
   int hold_left = 0;
   always @(posedge clock) begin
      if (rsp_valid && !rsp_stall && !reset) begin
         if (pending_beats.size() == 0) begin
            report("unexpected beat channel", rsp_out_channel, -1);
         end else begin
            meter_beat_type w;
            w = pending_beats.pop_front();
            if (rsp_out_channel !== w.ch) report("out_channel", rsp_out_channel, w.ch);
            if (rsp_block_peak_db !== w.bdb) report("block_peak_db", rsp_block_peak_db, w.bdb);
            if (rsp_held_peak_db !== w.held) report("held_peak_db", rsp_held_peak_db, w.held);
            if (rsp_max_peak_db !== w.mx) report("max_peak_db", rsp_max_peak_db, w.mx);
         end
      end
      if (hold_req && hold_left == 0) hold_left <= 400;
      else if (hold_left > 0) hold_left <= hold_left - 1;
      rsp_stall <= (hold_left > 1) || (hold_req && hold_left == 0) ||
                   ($urandom_range(99) < stall_pct);
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         dog <= 0;
      else
         dog <= dog + 1;
      if (dog >= DOG_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   dir_row_type dir_tab[19];
   int idle_mix[4][2] = '{'{0, 0}, '{87, 0}, '{0, 87}, '{11, 11}};

   initial begin
      meter_reset();
      dir_tab = '{
         '{0, 0, 24'h800000, 1, 1, '{0, 0, 0, 0}},
         '{0, 1, 24'h000000, 1, 1, '{1, 16'(DB_FLOOR), 17'(DB_FLOOR), 17'(DB_FLOOR)}},
         '{0, 0, 24'h7FFFFF, 0, 0, '{default: '0}},
         '{0, 0, 24'hFFFFFF, 1, 0, '{default: '0}},
         '{1, 0, 24'h000000, 0, 0, '{default: '0}},
         '{0, 1, 24'h000001, 1, 1, '{1, 16'(DB_FLOOR), 17'(DB_FLOOR), 17'(DB_FLOOR)}},
         '{0, 2, 24'h000005, 1, 0, '{default: '0}},
         '{0, 15, 24'h800000, 1, 0, '{default: '0}},
         '{0, 0, 24'h5A5A5A, 0, 0, '{default: '0}},
         '{0, 0, 24'hA5A5A5, 1, 0, '{default: '0}},
         '{0, 0, 24'h000001, 1, 0, '{default: '0}},
         '{0, 0, 24'h000010, 1, 0, '{default: '0}},
         '{0, 1, 24'h400000, 0, 0, '{default: '0}},
         '{0, 1, 24'hC00000, 1, 0, '{default: '0}},
         '{0, 1, 24'h000100, 1, 0, '{default: '0}},
         '{0, 1, 24'hFF0000, 1, 0, '{default: '0}},
         '{1, 15, 24'hFFFFFF, 1, 0, '{default: '0}},
         '{0, 0, 24'h000002, 1, 0, '{default: '0}},
         '{0, 0, 24'h7FFFFF, 1, 0, '{default: '0}}
      };
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_tab[i])
         send_item(dir_tab[i].typ, dir_tab[i].ch, dir_tab[i].smp, dir_tab[i].be,
                   dir_tab[i].typed, dir_tab[i].want);

      // saturate the decay accumulator on channel 0 and drop the held peak to its floor
      csr_write(CSR_DECAY, 24'hFFFFFF);
      send_item(0, 0, 24'h7FFFFF, 1, 0, '{default: '0});
      for (int i = 0; i < 10; i++) send_item(0, 0, 24'h000003, 0, 0, '{default: '0});
      send_item(0, 0, 24'h000001, 1, 0, '{default: '0});
      for (int i = 0; i < 4; i++) send_item(0, 0, 24'h000001, 1, 0, '{default: '0});

      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: csr_write(CSR_DECAY, 24'd0);
            1: csr_write(CSR_DECAY, 24'($urandom));
            2: csr_write(CSR_DECAY, 24'($urandom_range(4096)));
            default: csr_write(CSR_DECAY, 24'd16);
         endcase
         send_idle = idle_mix[ph][0];
         stall_pct = idle_mix[ph][1];
         for (int i = 0; i < 150; i++) begin
            if (ph == 0 && i == 50) hold_req <= 1'b1;
            if (ph == 0 && i == 52) hold_req <= 1'b0;
            if (ph == 1 && i == 75) begin
               req_valid <= 1'b0;
               while (pending_beats.size() != 0) @(posedge clock);
            end
            send_random();
         end
         if (ph == 2) begin
            csr_write(CSR_ENABLE, 1'b0);
            for (int i = 0; i < 20; i++) send_random();
            csr_write(CSR_ENABLE, 1'b1);
         end
      end

      send_idle = 0;
      stall_pct = 0;
      drain();
      if (errors == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end

endmodule

>>> files.f
rtl/pmad_pkg.sv
rtl/pmad_log.sv
rtl/peak_meter_accel_decay.sv
test/peak_meter_accel_decay_tb.sv
